// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks: same-cycle implication and next-cycle implication.
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: sv/ipt_pkg.sv
package ipt_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam int TE_W    = 5;
   localparam int PS_W    = 17;
   localparam int PID_W   = 16;
   localparam int VPN_W   = 20;
   localparam int OFF_W   = 16;
   localparam int PA_W    = 20;
   localparam int FRAME_W = 4;

   localparam logic [TE_W-1:0] TE_RESET = 5'd16;
   localparam logic [PS_W-1:0] PS_RESET = 17'd4096;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_ENTRIES = 1'b0,
      CSR_PAGE_SIZE     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [VPN_W-1:0] vpn;
   } tag_type;

endpackage

// File: sv/ipt_req_if.sv
interface ipt_req_if;
   import ipt_pkg::*;

   logic             valid;
   logic             ready;
   logic [PID_W-1:0] process_id;
   logic [VPN_W-1:0] virtual_page;
   logic [OFF_W-1:0] page_offset;

   modport source (output valid, output process_id, output virtual_page,
                   output page_offset, input ready);
   modport sink   (input valid, input process_id, input virtual_page,
                   input page_offset, output ready);
endinterface

// File: sv/ipt_rsp_if.sv
interface ipt_rsp_if;
   import ipt_pkg::*;

   logic               valid;
   logic               ready;
   logic [PA_W-1:0]    physical_address;
   logic [FRAME_W-1:0] frame_index;
   logic               was_hit;

   modport source (output valid, output physical_address, output frame_index,
                   output was_hit, input ready);
   modport sink   (input valid, input physical_address, input frame_index,
                   input was_hit, output ready);
endinterface

// File: sv/ipt_tag_store.sv
module ipt_tag_store #(
   parameter int ENTRIES = ipt_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  ipt_pkg::tag_type wr_tag,
   input  ipt_pkg::tag_type key,
   output logic             match
);
   import ipt_pkg::*;

   tag_type mem [ENTRIES];
   tag_type rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_tag;
      end
      if (rd_en) begin
         rd_tag_ff <= mem[rd_idx];
      end
   end

   // Shared comparator: one stored tag against the request key per cycle.
   assign match = (rd_tag_ff == key);
endmodule

// File: sv/ipt_rank_table.sv
module ipt_rank_table #(
   parameter int ENTRIES = ipt_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic              rd_valid,
   output logic [RANK_W-1:0] rd_rank,
   input  logic              touch,
   input  logic [IDX_W-1:0]  touch_idx
);
   import ipt_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0] valid_ff;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   old_rank;

   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

   // A fresh entry enters behind every valid one, so its old age is the count.
   assign old_rank = valid_ff[touch_idx] ? CNT_W'(rank_ff[touch_idx]) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int j = 0; j < ENTRIES; j++) begin
            rank_ff[j] <= '0;
         end
      end else if (touch) begin
         for (int j = 0; j < ENTRIES; j++) begin
            if (IDX_W'(j) == touch_idx) begin
               rank_ff[j] <= '0;
            end else if (valid_ff[j] && (CNT_W'(rank_ff[j]) < old_rank)) begin
               rank_ff[j] <= rank_ff[j] + RANK_W'(1);
            end
         end
         valid_ff[touch_idx] <= 1'b1;
         if (!valid_ff[touch_idx]) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end
endmodule

// File: sv/inverted_page_table_lru_top.sv
// Inverted page table translator with least-recently-used replacement.
// Request channel req_ch carries process_id, virtual_page and page_offset;
// response channel rsp_ch returns physical_address, frame_index and was_hit,
// one response per request, in order. Both use valid/ready beats.
// The csr_ port writes table_entries (index 0) and page_size (index 1);
// write only while no request is in flight.
// A request scans the active entries one per cycle through the single read
// port of the tag memory and one tag comparator, stopping at the first hit.
// After its scan a request passes through the update state, where the
// response is registered; a new request is taken the cycle after the
// update at the earliest, as req_ch is ready only in the idle state.
// Reset clears all valid bits and recency ranks and loads table_entries 16
// and page_size 4096; tags need no clearing since they are read only behind
// a set valid bit. The response waits in an output register while the sink
// stalls; the next request is still taken and scanned, and holds in its
// update cycle until that register is free.
`include "assert_macros.svh"

module inverted_page_table_lru_top #(
   parameter int ENTRIES = ipt_pkg::ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   ipt_req_if.sink                    req_ch,
   ipt_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  ipt_pkg::csr_index_type     csr_index,
   input  logic [ipt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ipt_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int PROD_W = IDX_W + PS_W;

   state_type state_ff, state_in;

   logic [TE_W-1:0]    te_ff;
   logic [PS_W-1:0]    ps_ff;

   tag_type            key_ff, key_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [RANK_W-1:0]  best_rank_ff, best_rank_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   frame_ff, frame_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_hit_ff, rsp_hit_in;

   logic               req_fire;
   logic               upd_fire;
   logic [CNT_W-1:0]   act_n;
   logic [CNT_W-1:0]   last_idx;
   logic [IDX_W-1:0]   frame_sel;
   logic [PROD_W-1:0]  prod;

   logic               ts_rd_en;
   logic [IDX_W-1:0]   ts_rd_idx;
   logic               ts_match;
   logic [IDX_W-1:0]   rk_rd_idx;
   logic               rk_rd_valid;
   logic [RANK_W-1:0]  rk_rd_rank;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         te_ff <= TE_RESET;
         ps_ff <= PS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TABLE_ENTRIES: te_ff <= csr_wdata[TE_W-1:0];
            CSR_PAGE_SIZE:     ps_ff <= csr_wdata[PS_W-1:0];
            default:           ;
         endcase
      end
   end

   // Clamp the active entry count to 1..ENTRIES.
   always_comb begin
      if (te_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (int'(te_ff) > ENTRIES) begin
         act_n = CNT_W'(ENTRIES);
      end else begin
         act_n = CNT_W'(te_ff);
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign upd_fire     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ch.ready);
   assign last_idx     = n_ff - CNT_W'(1);
   assign frame_sel    = hit_ff ? frame_ff : (empty_found_ff ? empty_idx_ff : best_idx_ff);
   assign prod         = PROD_W'(frame_sel) * PROD_W'(ps_ff);

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      off_in         = off_ff;
      n_in           = n_ff;
      scan_in        = scan_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_idx_in    = best_idx_ff;
      best_rank_in   = best_rank_ff;
      hit_in         = hit_ff;
      frame_in       = frame_ff;
      ts_rd_en       = 1'b0;
      ts_rd_idx      = scan_ff[IDX_W-1:0];
      rk_rd_idx      = (state_ff == ST_UPDATE) ? frame_sel : cmp_idx_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in    = rsp_addr_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_hit_in     = rsp_hit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in.pid     = req_ch.process_id;
               key_in.vpn     = req_ch.virtual_page;
               off_in         = req_ch.page_offset;
               n_in           = act_n;
               scan_in        = '0;
               empty_found_in = 1'b0;
               hit_in         = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue stage: read the next entry.
            if (scan_ff < n_ff) begin
               ts_rd_en     = 1'b1;
               scan_in      = scan_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
            end
            // Compare stage: entry read last cycle.
            if (cmp_valid_ff) begin
               if (rk_rd_valid && ts_match) begin
                  hit_in   = 1'b1;
                  frame_in = cmp_idx_ff;
                  state_in = ST_UPDATE;
               end else begin
                  if (!rk_rd_valid && !empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in   = cmp_idx_ff;
                  end
                  if (rk_rd_valid && ((cmp_idx_ff == '0) || (rk_rd_rank > best_rank_ff))) begin
                     best_idx_in  = cmp_idx_ff;
                     best_rank_in = rk_rd_rank;
                  end
                  if (CNT_W'(cmp_idx_ff) == last_idx) begin
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_UPDATE: begin
            // Hold until the output register can take the result.
            if (upd_fire) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = PA_W'(prod) + PA_W'(off_ff);
               rsp_frame_in = FRAME_W'(frame_sel);
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      off_ff         <= off_in;
      n_ff           <= n_in;
      scan_ff        <= scan_in;
      cmp_idx_ff     <= cmp_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      best_idx_ff    <= best_idx_in;
      best_rank_ff   <= best_rank_in;
      hit_ff         <= hit_in;
      frame_ff       <= frame_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_hit_ff     <= rsp_hit_in;
   end

   ipt_tag_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_tag_store (
      .clock  (clock),
      .rd_en  (ts_rd_en),
      .rd_idx (ts_rd_idx),
      .wr_en  (upd_fire && !hit_ff),
      .wr_idx (frame_sel),
      .wr_tag (key_ff),
      .key    (key_ff),
      .match  (ts_match)
   );

   ipt_rank_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .RANK_W  (RANK_W)
   ) u_rank_table (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rk_rd_idx),
      .rd_valid  (rk_rd_valid),
      .rd_rank   (rk_rd_rank),
      .touch     (upd_fire),
      .touch_idx (frame_sel)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.physical_address = rsp_addr_ff;
   assign rsp_ch.frame_index      = rsp_frame_ff;
   assign rsp_ch.was_hit          = rsp_hit_ff;

   `ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_fire, state_ff == ST_SCAN)
   `ASSERT_IMPLY(a_compare_in_range, clock, reset, cmp_valid_ff && (state_ff == ST_SCAN), CNT_W'(cmp_idx_ff) < n_ff)
   `ASSERT_IMPLY(a_hit_on_valid_entry, clock, reset, (state_ff == ST_UPDATE) && hit_ff, rk_rd_valid)
   `ASSERT_IMPLY(a_rsp_after_update, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_UPDATE)
endmodule
